// ----- rtl/core/gled_pkg.sv -----
package gled_pkg;

   localparam int unsigned SampleW    = 16;
   localparam int unsigned FrameW     = 16;
   localparam int unsigned IdxW       = 10;
   localparam int unsigned CsrDataW   = 11;
   localparam int unsigned CsrIdxW    = 2;
   localparam int unsigned DefMaxCols = 1024;
   localparam int unsigned DefMaxRows = 1024;
   localparam int unsigned DimReset   = 1024;
   localparam int unsigned DimMin     = 3;
   localparam int unsigned RspDepth   = 4;

   localparam logic [CsrIdxW-1:0] CSR_GRID_COLUMNS = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_GRID_ROWS    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_INVERT_SENSE = 2'd2;

   localparam logic KIND_MAX = 1'b0;
   localparam logic KIND_MIN = 1'b1;

   typedef logic signed [SampleW-1:0] sample_type;

   typedef struct packed {
      logic              kind;
      logic [FrameW-1:0] frame_index;
      logic [IdxW-1:0]   row_index;
      logic [IdxW-1:0]   col_index;
      sample_type        value;
   } result_type;

   typedef struct packed {
      logic       is_max;
      logic       is_min;
      sample_type centre;
   } verdict_type;

endpackage

// ----- rtl/core/gled_chan_if.sv -----
interface gled_req_if;
   import gled_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface gled_rsp_if;
   import gled_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [FrameW-1:0] frame_index;
   logic [IdxW-1:0]   row_index;
   logic [IdxW-1:0]   col_index;
   sample_type        value;
   modport source (output valid, output kind, output frame_index, output row_index,
                   output col_index, output value, input ready);
   modport sink (input valid, input kind, input frame_index, input row_index,
                 input col_index, input value, output ready);
endinterface

// ----- rtl/core/gled_ram.sv -----
module gled_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/gled_window.sv -----
module gled_window (
   input  logic                  clock,
   input  logic                  shift,
   input  gled_pkg::sample_type  top,
   input  gled_pkg::sample_type  mid,
   input  gled_pkg::sample_type  bot,
   output gled_pkg::verdict_type verdict
);
   import gled_pkg::*;

   // far holds the column two places back, near the previous column.
   sample_type far_ff  [3];
   sample_type far_in  [3];
   sample_type near_ff [3];
   sample_type near_in [3];
   sample_type nb      [8];
   sample_type centre;
   logic [7:0] gt;
   logic [7:0] lt;

   always_comb begin
      far_in  = far_ff;
      near_in = near_ff;
      if (shift) begin
         far_in  = near_ff;
         near_in = '{top, mid, bot};
      end
   end

   always_ff @(posedge clock) begin
      far_ff  <= far_in;
      near_ff <= near_in;
   end

   // The window seen by the incoming column: far, near and the new column.
   always_comb begin
      centre = near_ff[1];
      nb     = '{far_ff[0], far_ff[1], far_ff[2], near_ff[0], near_ff[2], top, mid, bot};
      for (int i = 0; i < 8; i++) begin
         gt[i] = centre > nb[i];
         lt[i] = centre < nb[i];
      end
      verdict.is_max = &gt;
      verdict.is_min = &lt;
      verdict.centre = centre;
   end

endmodule

// ----- rtl/core/gled_rsp_fifo.sv -----
module gled_rsp_fifo #(
   parameter int unsigned DEPTH = gled_pkg::RspDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gled_pkg::result_type       push_data,
   input  logic                       pop,
   output logic                       out_valid,
   output gled_pkg::result_type       out_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import gled_pkg::*;

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   result_type      slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      logic [PtrW-1:0] r;
      r = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- rtl/core/grid_local_extremum_detector.sv -----
// Channel   Direction  Contents
// req_ch    in         sample: one signed grid value, raster order
// rsp_ch    out        kind, frame_index, row_index, col_index, value of an extremum
// csr_*     in         write enable, register index and data, no read-back
//
// One request per cycle is taken; a result is registered in stage one and then in the
// result queue. Both previous rows live in one line RAM read at request time and
// written back in the next cycle. Requests stall only while the four-entry result
// queue is backed up. Reset is synchronous and clears the counters, the registers and
// the queue; the line RAM is not cleared, as every entry is written before it is used.
module grid_local_extremum_detector #(
   parameter int unsigned MAX_COLS = gled_pkg::DefMaxCols,
   parameter int unsigned MAX_ROWS = gled_pkg::DefMaxRows
) (
   input  logic                           clock,
   input  logic                           reset,
   gled_req_if.sink                       req_ch,
   gled_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [gled_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [gled_pkg::CsrDataW-1:0]  csr_wr_data
);
   import gled_pkg::*;

   localparam int unsigned ColW    = $clog2(MAX_COLS);
   localparam int unsigned RowW    = $clog2(MAX_ROWS);
   localparam int unsigned ColDimW = $clog2(MAX_COLS + 1);
   localparam int unsigned RowDimW = $clog2(MAX_ROWS + 1);
   localparam int unsigned ColsRst = (DimReset > MAX_COLS) ? MAX_COLS : DimReset;
   localparam int unsigned RowsRst = (DimReset > MAX_ROWS) ? MAX_ROWS : DimReset;
   localparam int unsigned LineW   = 2 * SampleW;
   localparam int unsigned CntW    = $clog2(RspDepth + 1);

   typedef struct packed {
      sample_type        sample;
      logic [ColW-1:0]   addr;
      logic              elig;
      logic [IdxW-1:0]   row_index;
      logic [IdxW-1:0]   col_index;
      logic [FrameW-1:0] frame_index;
      logic              invert;
   } stage_type;

   function automatic logic [31:0] clamp_dim(input logic [CsrDataW-1:0] v,
                                            input int unsigned hi);
      logic [31:0] w;
      w = 32'(v);
      if (w < DimMin) begin
         w = DimMin;
      end else if (w > hi) begin
         w = hi;
      end
      return w;
   endfunction

   logic [ColDimW-1:0] cols_ff;
   logic [ColDimW-1:0] cols_in;
   logic [RowDimW-1:0] rows_ff;
   logic [RowDimW-1:0] rows_in;
   logic               invert_ff;
   logic               invert_in;

   logic [ColW-1:0]    col_ff;
   logic [ColW-1:0]    col_in;
   logic [RowW-1:0]    row_ff;
   logic [RowW-1:0]    row_in;
   logic [FrameW-1:0]  frame_ff;
   logic [FrameW-1:0]  frame_in;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   stage_type          s1_ff;
   stage_type          s1_in;

   logic               accept;
   logic               col_last;
   logic               row_last;
   logic               eligible;
   logic [31:0]        row_m1;
   logic [31:0]        col_m1;
   logic [LineW-1:0]   line_rd;
   verdict_type        verdict;
   logic               push;
   result_type         result;
   result_type         rsp_data;
   logic [CntW-1:0]    fifo_count;

   always_comb begin
      cols_in   = cols_ff;
      rows_in   = rows_ff;
      invert_in = invert_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: begin
               cols_in = ColDimW'(clamp_dim(csr_wr_data, MAX_COLS));
            end
            CSR_GRID_ROWS: begin
               rows_in = RowDimW'(clamp_dim(csr_wr_data, MAX_ROWS));
            end
            CSR_INVERT_SENSE: begin
               invert_in = csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // A result slot is reserved for every request in flight, so stage one never stalls.
   assign req_ch.ready = (32'(fifo_count) + 32'(s1_valid_ff)) <= 32'(RspDepth - 1);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      col_last = (32'(col_ff) + 32'd1) >= 32'(cols_ff);
      row_last = (32'(row_ff) + 32'd1) >= 32'(rows_ff);
      eligible = (32'(row_ff) >= 32'd2) && (32'(col_ff) >= 32'd2) &&
                 (32'(row_ff) < 32'(rows_ff)) && (32'(col_ff) < 32'(cols_ff));
      row_m1   = 32'(row_ff) - 32'd1;
      col_m1   = 32'(col_ff) - 32'd1;

      col_in   = col_ff;
      row_in   = row_ff;
      frame_in = frame_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in   = '0;
               frame_in = frame_ff + FrameW'(1);
            end else begin
               row_in = row_ff + RowW'(1);
            end
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end

      s1_valid_in       = accept;
      s1_in             = s1_ff;
      if (accept) begin
         s1_in.sample      = req_ch.sample;
         s1_in.addr        = col_ff;
         s1_in.elig        = eligible;
         s1_in.row_index   = row_m1[IdxW-1:0];
         s1_in.col_index   = col_m1[IdxW-1:0];
         s1_in.frame_index = frame_ff;
         s1_in.invert      = invert_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= ColDimW'(ColsRst);
         rows_ff     <= RowDimW'(RowsRst);
         invert_ff   <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         frame_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cols_ff     <= cols_in;
         rows_ff     <= rows_in;
         invert_ff   <= invert_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         frame_ff    <= frame_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // Each entry holds {two rows up, one row up} for its column. Consecutive requests
   // always use different columns, so the write-back never meets a read of its entry.
   gled_ram #(
      .WIDTH(LineW),
      .DEPTH(MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.addr),
      .wr_data ({line_rd[SampleW-1:0], s1_ff.sample}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   gled_window u_window (
      .clock   (clock),
      .shift   (s1_valid_ff),
      .top     (line_rd[LineW-1:SampleW]),
      .mid     (line_rd[SampleW-1:0]),
      .bot     (s1_ff.sample),
      .verdict (verdict)
   );

   always_comb begin
      push               = s1_valid_ff && s1_ff.elig && (verdict.is_max || verdict.is_min);
      result.kind        = (verdict.is_max ? KIND_MAX : KIND_MIN) ^ s1_ff.invert;
      result.frame_index = s1_ff.frame_index;
      result.row_index   = s1_ff.row_index;
      result.col_index   = s1_ff.col_index;
      result.value       = verdict.centre;
   end

   gled_rsp_fifo #(
      .DEPTH(RspDepth)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (rsp_ch.valid && rsp_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   assign rsp_ch.kind        = rsp_data.kind;
   assign rsp_ch.frame_index = rsp_data.frame_index;
   assign rsp_ch.row_index   = rsp_data.row_index;
   assign rsp_ch.col_index   = rsp_data.col_index;
   assign rsp_ch.value       = rsp_data.value;

endmodule

// ----- rtl/core/gled_checker.sv -----
module gled_checker (
   input logic        clock,
   input logic        reset,
   gled_req_if.sink   req_ch,
   gled_rsp_if.source rsp_ch
);

   // A result waiting to be taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("result withdrawn while stalled");

   // An empty queue only fills from a request taken earlier and registered in stage one.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(req_ch.valid && req_ch.ready, 2))
      else $error("result without a matching request");

   // Requests are only held off while results are backed up.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("request stalled with no result pending");

   // Reset leaves no result behind.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result offered straight after reset");

endmodule

bind grid_local_extremum_detector gled_checker u_gled_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

// ----- tb/sv/grid_local_extremum_detector_tb.sv -----
`timescale 1ns / 100ps

module grid_local_extremum_detector_tb;
   import gled_pkg::*;

   localparam int unsigned MaxCols        = DefMaxCols;
   localparam int unsigned MaxRows        = DefMaxRows;
   localparam int unsigned NeighbourCount = 8;
   localparam int unsigned SettleCycles   = 8;
   localparam int unsigned RandomTarget   = 1300;
   localparam int unsigned WideSamples    = 64;
   localparam int unsigned TallSamples    = 120;
   localparam int unsigned AlignLimit     = 400;
   localparam int unsigned MaxReports     = 50;
   localparam logic [CsrIdxW-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      sample_type level;
      bit         hold_for_drain;
   } grid_item_type;

   logic clock = 1'b0;
   logic reset;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wr_data;

   gled_req_if req_if ();
   gled_rsp_if rsp_if ();

   grid_local_extremum_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Predictor state: registers as last written, the two line stores, the 3x3 neighbourhood
   // and the raster counters.
   logic [CsrDataW-1:0] cfg_cols;
   logic [CsrDataW-1:0] cfg_rows;
   logic                cfg_invert;
   sample_type          row_above [MaxCols];
   sample_type          row_two_above [MaxCols];
   sample_type          nbhd [3][3];
   int unsigned         col_pos;
   int unsigned         row_pos;
   logic [FrameW-1:0]   frame_no;

   grid_item_type pending_samples [$];
   result_type    extrema_due [$];
   int unsigned   queued_count = 0;
   int unsigned   accepted_count = 0;
   int unsigned   error_count = 0;
   int unsigned   send_wait = 0;
   int unsigned   recv_wait = 0;
   bit            send_idle = 1'b1;
   bit            recv_idle = 1'b1;
   bit            req_taken = 1'b0;
   bit            rsp_taken = 1'b0;

   function automatic int unsigned effective_dim(input logic [CsrDataW-1:0] v,
                                                 input int unsigned hi);
      if (v < DimMin) return DimMin;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic int unsigned draw_wait(input bit enabled);
      return enabled ? $urandom_range(0, 11) : 0;
   endfunction

   function automatic sample_type draw_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sample_type'($urandom);
         4, 5, 6: return sample_type'(int'($urandom_range(0, 4)) - 2);
         7: begin
            case ($urandom_range(0, 3))
               0: return sample_type'(16'h7FFF);
               1: return sample_type'(16'h8000);
               2: return sample_type'(16'h7FFE);
               default: return sample_type'(16'h8001);
            endcase
         end
         default: return sample_type'(int'($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   function automatic logic [CsrDataW-1:0] draw_dim();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return CsrDataW'($urandom_range(0, 2));
      if (pick < 85) return CsrDataW'($urandom_range(3, 12));
      return CsrDataW'($urandom_range(13, 24));
   endfunction

   // Number of samples still to come before the raster counters return to the frame start.
   function automatic int unsigned samples_to_frame_end();
      int unsigned cols, rows, c, r, n;
      cols = effective_dim(cfg_cols, MaxCols);
      rows = effective_dim(cfg_rows, MaxRows);
      c = col_pos;
      r = row_pos;
      n = 0;
      do begin
         n++;
         if (c + 1 >= cols) begin
            c = 0;
            r = (r + 1 >= rows) ? 0 : r + 1;
         end else begin
            c++;
         end
      end while (c != 0 || r != 0);
      return n;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MaxReports) $display("error at %0t: %s", $realtime, what);
   endtask

   task automatic predict_extremum(input sample_type s);
      int unsigned cols, rows, c, r, higher, lower;
      sample_type  top, mid, centre;
      result_type  hit;
      cols = effective_dim(cfg_cols, MaxCols);
      rows = effective_dim(cfg_rows, MaxRows);
      c = col_pos;
      r = row_pos;
      top = '0;
      mid = '0;
      if (c < MaxCols) begin
         top = row_two_above[c];
         mid = row_above[c];
         row_two_above[c] = mid;
         row_above[c] = s;
      end
      for (int i = 0; i < 3; i++) begin
         nbhd[i][0] = nbhd[i][1];
         nbhd[i][1] = nbhd[i][2];
      end
      nbhd[0][2] = top;
      nbhd[1][2] = mid;
      nbhd[2][2] = s;

      if (r >= 2 && c >= 2 && r < rows && c < cols) begin
         centre = nbhd[1][1];
         higher = 0;
         lower = 0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (i != 1 || j != 1) begin
                  if (centre > nbhd[i][j]) higher++;
                  if (centre < nbhd[i][j]) lower++;
               end
            end
         end
         if (higher == NeighbourCount || lower == NeighbourCount) begin
            hit.kind        = ((higher == NeighbourCount) ? KIND_MAX : KIND_MIN) ^ cfg_invert;
            hit.frame_index = frame_no;
            hit.row_index   = IdxW'(r - 1);
            hit.col_index   = IdxW'(c - 1);
            hit.value       = centre;
            extrema_due.push_back(hit);
         end
      end

      if (c + 1 >= cols) begin
         col_pos = 0;
         if (r + 1 >= rows) begin
            row_pos = 0;
            frame_no = frame_no + FrameW'(1);
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      req_taken = !reset && req_if.valid === 1'b1 && req_if.ready === 1'b1;
      rsp_taken = !reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1;
      if (req_taken) begin
         accepted_count++;
         predict_extremum(req_if.sample);
      end
      if (rsp_taken) begin
         if (extrema_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result at frame %0d row %0d col %0d",
                                      rsp_if.frame_index, rsp_if.row_index, rsp_if.col_index));
         end else begin
            want = extrema_due.pop_front();
            if (rsp_if.kind !== want.kind)
               report_mismatch($sformatf("kind %b, expected %b", rsp_if.kind, want.kind));
            if (rsp_if.frame_index !== want.frame_index)
               report_mismatch($sformatf("frame_index %0d, expected %0d",
                                         rsp_if.frame_index, want.frame_index));
            if (rsp_if.row_index !== want.row_index)
               report_mismatch($sformatf("row_index %0d, expected %0d",
                                         rsp_if.row_index, want.row_index));
            if (rsp_if.col_index !== want.col_index)
               report_mismatch($sformatf("col_index %0d, expected %0d",
                                         rsp_if.col_index, want.col_index));
            if (rsp_if.value !== want.value)
               report_mismatch($sformatf("value %0d, expected %0d", rsp_if.value, want.value));
         end
      end
   end

   // Request driver: a request is held until taken; a flagged request waits until every
   // outstanding result has been returned.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.sample <= '0;
      end else if (!(req_if.valid && !req_taken)) begin
         if (send_wait != 0) begin
            send_wait--;
            req_if.valid <= 1'b0;
         end else if (pending_samples.size() != 0 &&
                      (!pending_samples[0].hold_for_drain || extrema_due.size() == 0)) begin
            req_if.valid <= 1'b1;
            req_if.sample <= pending_samples[0].level;
            pending_samples.pop_front();
            send_wait = draw_wait(send_idle);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) recv_wait = draw_wait(recv_idle);
         if (recv_wait != 0) begin
            recv_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic push_sample(input sample_type s, input bit hold);
      grid_item_type item;
      item.level = s;
      item.hold_for_drain = hold;
      pending_samples.push_back(item);
      queued_count++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || extrema_due.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_GRID_COLUMNS: cfg_cols = data;
         CSR_GRID_ROWS:    cfg_rows = data;
         CSR_INVERT_SENSE: cfg_invert = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // A 4x3 frame with a peak and a trough side by side in the middle row.
   task automatic push_pair_frame(input sample_type left, input sample_type right);
      for (int k = 0; k < 12; k++) begin
         push_sample((k == 5) ? left : ((k == 6) ? right : sample_type'(0)), 1'b0);
      end
   endtask

   initial begin
      int unsigned random_sent, n, gap;
      logic [CsrDataW-1:0] new_cols;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_GRID_COLUMNS;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      rsp_if.ready = 1'b0;
      cfg_cols = CsrDataW'(DimReset);
      cfg_rows = CsrDataW'(DimReset);
      cfg_invert = 1'b0;
      col_pos = 0;
      row_pos = 0;
      frame_no = '0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) nbhd[i][j] = '0;
      for (int i = 0; i < MaxCols; i++) begin
         row_above[i] = '0;
         row_two_above[i] = '0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames: a full-scale peak and trough, then a trough and peak with the sense swapped.
      write_reg(CSR_GRID_COLUMNS, 11'd4);
      write_reg(CSR_GRID_ROWS, 11'd3);
      write_reg(CSR_INVERT_SENSE, 11'd0);
      write_reg(CSR_SPARE, CsrDataW'($urandom_range(0, 2047)));
      push_pair_frame(sample_type'(16'h7FFF), sample_type'(16'h8000));
      wait_idle();
      write_reg(CSR_INVERT_SENSE, CsrDataW'(($urandom_range(0, 1023) << 1) | 1));
      push_pair_frame(sample_type'(16'h8000), sample_type'(16'h7FFF));
      wait_idle();

      // The start of a wide frame, then part of a tall frame, both with dimensions beyond
      // the legal range.
      send_idle = 1'b0;
      recv_idle = 1'b1;
      write_reg(CSR_GRID_COLUMNS, 11'd2047);
      write_reg(CSR_GRID_ROWS, 11'd0);
      write_reg(CSR_INVERT_SENSE, 11'd0);
      repeat (WideSamples) push_sample(draw_sample(), 1'b0);
      wait_idle();
      send_idle = 1'b1;
      recv_idle = ($urandom_range(0, 1) == 1);
      write_reg(CSR_GRID_COLUMNS, 11'd2);
      write_reg(CSR_GRID_ROWS, 11'd2047);
      repeat (TallSamples) push_sample(draw_sample(), 1'b0);
      wait_idle();

      random_sent = 0;
      while (random_sent < RandomTarget) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 6) begin
            new_cols = draw_dim();
            // Widening mid-frame would expose line store entries never written, so the
            // current frame is finished first, or the width is kept.
            if (effective_dim(new_cols, MaxCols) > effective_dim(cfg_cols, MaxCols) &&
                (col_pos != 0 || row_pos != 0)) begin
               gap = samples_to_frame_end();
               if (gap <= AlignLimit) begin
                  repeat (gap) push_sample(draw_sample(), 1'b0);
                  random_sent += gap;
                  wait_idle();
               end else begin
                  new_cols = cfg_cols;
               end
            end
            write_reg(CSR_GRID_COLUMNS, new_cols);
         end
         if ($urandom_range(0, 9) < 6) write_reg(CSR_GRID_ROWS, draw_dim());
         if ($urandom_range(0, 9) < 4)
            write_reg(CSR_INVERT_SENSE, CsrDataW'($urandom_range(0, 2047)));
         if ($urandom_range(0, 19) == 0)
            write_reg(CSR_SPARE, CsrDataW'($urandom_range(0, 2047)));
         n = $urandom_range(20, 160);
         for (int k = 0; k < n; k++) push_sample(draw_sample(), $urandom_range(0, 99) == 0);
         random_sent += n;
         wait_idle();
      end

      if (error_count == 0) begin
         $display("grid_local_extremum_detector test passed");
      end else begin
         $display("grid_local_extremum_detector test failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("grid_local_extremum_detector test failed");
      $finish;
   end

endmodule
